FILE: rtl/mbdd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the marine bus datagram decoder
// no dependencies; imported by mbdd_decode and the top level

package mbdd_pkg;

    // datagram store geometry
    localparam int unsigned STORE_DEPTH = 5;
    localparam logic [3:0]  LEN_MAX     = 4'd15;

    // first-byte codes of the known datagrams
    localparam logic [7:0] CMD_WIND_ANGLE   = 8'h10;
    localparam logic [7:0] CMD_WIND_SPEED   = 8'h11;
    localparam logic [7:0] CMD_WATER_SPEED  = 8'h20;
    localparam logic [7:0] CMD_GROUND_SPEED = 8'h52;
    localparam logic [7:0] CMD_COURSE       = 8'h53;
    localparam logic [7:0] CMD_DEPTH        = 8'h00;
    localparam logic [7:0] CMD_AUTOPILOT    = 8'h84;
    localparam logic [7:0] CMD_ECHO         = 8'hAC;

    // datagram lengths in bytes
    localparam logic [3:0] LEN_SHORT     = 4'd4;
    localparam logic [3:0] LEN_DEPTH     = 4'd5;
    localparam logic [3:0] LEN_AUTOPILOT = 4'd9;

    // x / 10 == (x * DIV10_MAGIC) >> DIV10_SHIFT for any 16-bit x
    localparam logic [16:0] DIV10_MAGIC = 17'h0CCCD;
    localparam int unsigned DIV10_SHIFT = 19;

    // result kinds
    typedef enum logic [2:0] {
        KIND_WIND_ANGLE   = 3'd0,
        KIND_WIND_SPEED   = 3'd1,
        KIND_WATER_SPEED  = 3'd2,
        KIND_GROUND_SPEED = 3'd3,
        KIND_COURSE       = 3'd4,
        KIND_DEPTH        = 3'd5,
        KIND_AUTOPILOT    = 3'd6,
        KIND_ECHO         = 3'd7
    } t_kind;

    // snapshot of an open datagram after a data beat
    typedef struct packed {
        logic [3:0]                  len;
        logic [STORE_DEPTH-1:0][7:0] bytes;
    } t_frame;

endpackage

FILE: rtl/mbdd_decode.sv
`timescale 1ns / 1ps
// combinational decode of one datagram snapshot into a result
// depends on mbdd_pkg

module mbdd_decode
    import mbdd_pkg::*;
(
    input  t_frame      i_frame,
    output logic        o_hit,
    output t_kind       o_kind,
    output logic [15:0] o_value,
    output logic [8:0]  o_course
);

    logic [7:0]  w_b0, w_b1, w_b2, w_b3, w_b4;
    logic [15:0] w_num;
    logic [33:0] w_prod;
    logic [15:0] w_quot;
    logic [15:0] w_base;

    assign w_b0 = i_frame.bytes[0];
    assign w_b1 = i_frame.bytes[1];
    assign w_b2 = i_frame.bytes[2];
    assign w_b3 = i_frame.bytes[3];
    assign w_b4 = i_frame.bytes[4];

    // shared divide by ten: depth uses b4:b3, the speeds use b3:b2
    assign w_num  = (i_frame.len == LEN_DEPTH) ? {w_b4, w_b3} : {w_b3, w_b2};
    assign w_prod = 34'(w_num) * 34'(DIV10_MAGIC);
    assign w_quot = 16'(w_prod[33:DIV10_SHIFT]);

    // quadrant times 90 plus twice the low six bits of b2
    assign w_base = 16'(w_b1[5:4]) * 16'd90 + {9'd0, w_b2[5:0], 1'b0};

    // pick the result by length and first byte
    always_comb begin
        o_hit    = 1'b0;
        o_kind   = KIND_WIND_ANGLE;
        o_value  = '0;
        o_course = '0;
        if (i_frame.len == LEN_SHORT) begin
            case (w_b0)
                CMD_WIND_ANGLE: begin
                    o_hit   = 1'b1;
                    o_kind  = KIND_WIND_ANGLE;
                    o_value = {w_b2, w_b3};
                end
                CMD_WIND_SPEED: begin
                    o_hit   = 1'b1;
                    o_kind  = KIND_WIND_SPEED;
                    o_value = 16'(w_b2[6:0]) * 16'd10 + 16'(w_b3[3:0]);
                end
                CMD_WATER_SPEED: begin
                    o_hit   = 1'b1;
                    o_kind  = KIND_WATER_SPEED;
                    o_value = w_quot;
                end
                CMD_GROUND_SPEED: begin
                    o_hit   = 1'b1;
                    o_kind  = KIND_GROUND_SPEED;
                    o_value = w_quot;
                end
                CMD_COURSE: begin
                    o_hit   = 1'b1;
                    o_kind  = KIND_COURSE;
                    o_value = w_base + 16'(w_b1[7]);
                end
                CMD_ECHO: begin
                    o_hit   = (w_b1 == 8'h00);
                    o_kind  = KIND_ECHO;
                    o_value = 16'(w_b3);
                end
                default: begin
                    o_hit = 1'b0;
                end
            endcase
        end else if (i_frame.len == LEN_DEPTH && w_b0 == CMD_DEPTH) begin
            o_hit   = 1'b1;
            o_kind  = KIND_DEPTH;
            o_value = w_quot;
        end else if (i_frame.len == LEN_AUTOPILOT && w_b0 == CMD_AUTOPILOT) begin
            // odd-heading bits add one each, so both set gives two
            o_hit    = 1'b1;
            o_kind   = KIND_AUTOPILOT;
            o_value  = w_base + 16'(w_b1[7]) + 16'(w_b1[6]);
            o_course = 9'(w_b2[7:6]) * 9'd90 + 9'(w_b3[7:1]);
        end
    end

endmodule

FILE: rtl/marine_bus_datagram_decoder.sv
`timescale 1ns / 1ps
// a completing data beat passes the snapshot register, then the result register
// throughput: one beat per cycle; input stalls only while a data beat waits in the
// snapshot register behind a result that is not being taken
// reset: synchronous active low; clears the open flag, byte count and valid bits,
// the stored datagram bytes are not cleared; depends on mbdd_pkg and mbdd_decode

module marine_bus_datagram_decoder
    import mbdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_command,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_value,
    output logic [8:0]  o_course
);

    logic                        r_open;
    logic [3:0]                  r_len;
    logic [STORE_DEPTH-1:0][7:0] r_bytes;
    logic                        n_open;
    logic [3:0]                  n_len;
    logic [STORE_DEPTH-1:0][7:0] n_bytes;

    logic   r_snap_valid;
    t_frame r_snap;

    logic        r_out_valid;
    t_kind       r_kind;
    logic [15:0] r_value;
    logic [8:0]  r_course;

    logic        w_in_fire;
    logic        w_hit;
    t_kind       w_kind;
    logic [15:0] w_value;
    logic [8:0]  w_course;

    // pipeline moves when the snapshot is empty or the result register is free or drained
    assign o_ready   = !r_snap_valid || !r_out_valid || i_ready;
    assign w_in_fire = i_valid && o_ready;

    // datagram assembly: command restarts, data appends with saturating count
    always_comb begin
        n_open  = r_open;
        n_len   = r_len;
        n_bytes = r_bytes;
        if (i_is_command) begin
            n_bytes[0] = i_data_byte;
            n_len      = 4'd1;
            n_open     = 1'b1;
        end else if (r_open) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                if (r_len == 4'(k)) begin
                    n_bytes[k] = i_data_byte;
                end
            end
            if (r_len != LEN_MAX) begin
                n_len = r_len + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_len  <= '0;
        end else if (w_in_fire) begin
            r_open <= n_open;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_bytes <= n_bytes;
        end
    end

    // snapshot stage: one entry per data beat of an open datagram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (o_ready) begin
            r_snap_valid <= w_in_fire && !i_is_command && r_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_snap.len   <= n_len;
            r_snap.bytes <= n_bytes;
        end
    end

    mbdd_decode u_decode (
        .i_frame  (r_snap),
        .o_hit    (w_hit),
        .o_kind   (w_kind),
        .o_value  (w_value),
        .o_course (w_course)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= r_snap_valid && w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_kind   <= w_kind;
            r_value  <= w_value;
            r_course <= w_course;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_kind   = r_kind;
    assign o_value  = r_value;
    assign o_course = r_course;

`ifndef SYNTHESIS
    // a command beat always restarts the count at one
    a_cmd_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_is_command) |=> (r_len == 4'd1))
        else $error("count not restarted by command beat");

    // data beats into an open datagram never lower the count
    a_len_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !i_is_command && r_open) |=> (r_len >= $past(r_len)))
        else $error("byte count went down on a data beat");

    // the count holds once saturated
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !i_is_command && r_len == LEN_MAX) |=> (r_len == LEN_MAX))
        else $error("saturated byte count wrapped");

    // snapshots only exist once a datagram has been opened
    a_snap_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid |-> r_open)
        else $error("snapshot without open datagram");

    // course field is zero for every kind but autopilot
    a_course_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_kind != KIND_AUTOPILOT) |-> (o_course == 9'd0))
        else $error("course set on non-autopilot result");
`endif

endmodule

FILE: verif/tb_marine_bus_datagram_decoder.sv
`timescale 1ns / 1ps
// self-checking bench for marine_bus_datagram_decoder: directed and random bus beats
// depends on mbdd_pkg and the decoder rtl; predicts each decoded reading in step with the input

module tb_marine_bus_datagram_decoder
    import mbdd_pkg::*;
;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BEATS    = 650;

    // one decoded reading as the block presents it
    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic [8:0]  course;
    } t_reading;

    // one received bus beat
    typedef struct {
        logic [7:0] data;
        logic       cmd;
    } t_bus_beat;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_is_command = 1'b0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [15:0] o_value;
    logic [8:0]  o_course;

    // stimulus and scoreboard state
    t_bus_beat   beats_pending[$];
    t_reading    readings_due[$];
    t_reading    next_reading;
    t_reading    due_reading;
    int          beats_queued   = 0;
    int          beats_in       = 0;
    int          readings_out   = 0;
    int          mismatches     = 0;
    int          kind_seen[8];
    int          kinds_hit      = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;
    int          rx_hold_cnt    = 0;
    int          quiet_cycles   = 0;
    bit          rx_hold_req    = 1'b0;
    bit          beat_taken     = 1'b0;

    // predictor copy of the datagram store
    logic [7:0]  dg_bytes[STORE_DEPTH];
    logic [3:0]  dg_len  = 4'd0;
    bit          dg_open = 1'b0;

    marine_bus_datagram_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_is_command (i_is_command),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_course     (o_course)
    );

    // clock
    always #(CLK_HALF) i_clk = ~i_clk;

    // advance the datagram store by one beat, return 1 when a reading falls out
    function automatic bit predict_reading(input logic [7:0] rx, input logic cmd,
                                           output t_reading rd);
        int b1, b2, b3, b4, u, odd;
        bit hit;
        rd = '0;
        if (cmd) begin
            dg_bytes[0] = rx;
            dg_len      = 4'd1;
            dg_open     = 1'b1;
            return 1'b0;
        end
        if (!dg_open)
            return 1'b0;
        if (dg_len < STORE_DEPTH)
            dg_bytes[dg_len] = rx;
        if (dg_len < LEN_MAX)
            dg_len++;

        b1  = dg_bytes[1];
        b2  = dg_bytes[2];
        b3  = dg_bytes[3];
        b4  = dg_bytes[4];
        u   = (b1 >> 4) & 15;
        hit = 1'b1;
        if (dg_len == LEN_SHORT) begin
            case (dg_bytes[0])
                CMD_WIND_ANGLE: begin
                    rd.kind  = KIND_WIND_ANGLE;
                    rd.value = 16'((b2 << 8) | b3);
                end
                CMD_WIND_SPEED: begin
                    rd.kind  = KIND_WIND_SPEED;
                    rd.value = 16'((b2 & 127) * 10 + (b3 & 15));
                end
                CMD_WATER_SPEED: begin
                    rd.kind  = KIND_WATER_SPEED;
                    rd.value = 16'(((b3 << 8) | b2) / 10);
                end
                CMD_GROUND_SPEED: begin
                    rd.kind  = KIND_GROUND_SPEED;
                    rd.value = 16'(((b3 << 8) | b2) / 10);
                end
                CMD_COURSE: begin
                    rd.kind  = KIND_COURSE;
                    rd.value = 16'((u & 3) * 90 + (b2 & 63) * 2 + ((u >> 2) & 3) / 2);
                end
                CMD_ECHO: begin
                    // echo only answers when the second byte is zero
                    rd.kind  = KIND_ECHO;
                    rd.value = 16'(b3);
                    hit      = (b1 == 0);
                end
                default: hit = 1'b0;
            endcase
        end else if (dg_len == LEN_DEPTH && dg_bytes[0] == CMD_DEPTH) begin
            rd.kind  = KIND_DEPTH;
            rd.value = 16'(((b4 << 8) | b3) / 10);
        end else if (dg_len == LEN_AUTOPILOT && dg_bytes[0] == CMD_AUTOPILOT) begin
            // odd-heading bits add two only when both are set
            if ((u & 12) == 12)
                odd = 2;
            else if ((u & 12) != 0)
                odd = 1;
            else
                odd = 0;
            rd.kind   = KIND_AUTOPILOT;
            rd.value  = 16'((u & 3) * 90 + (b2 & 63) * 2 + odd);
            rd.course = 9'(((b2 & 192) >> 6) * 90 + b3 / 2);
        end else begin
            hit = 1'b0;
        end
        return hit;
    endfunction

    // queue one beat for the sender
    task automatic add_beat(input logic [7:0] data, input logic cmd);
        t_bus_beat bb;
        bb.data = data;
        bb.cmd  = cmd;
        beats_pending = {beats_pending, bb};
        beats_queued++;
    endtask

    // queue a command beat followed by its data beats
    task automatic queue_datagram(input logic [7:0] head, input logic [7:0] body[$]);
        add_beat(head, 1'b1);
        foreach (body[k])
            add_beat(body[k], 1'b0);
    endtask

    // mostly well-formed datagrams with random content, some cut short, run long or unknown
    task automatic queue_random_datagram();
        logic [7:0] head;
        logic [7:0] body[$];
        int         n_data;
        int         shape;
        logic [7:0] b;
        shape = $urandom_range(0, 99);
        if (shape < 85) begin
            case ($urandom_range(0, 7))
                0: begin head = CMD_WIND_ANGLE;   n_data = LEN_SHORT - 1;     end
                1: begin head = CMD_WIND_SPEED;   n_data = LEN_SHORT - 1;     end
                2: begin head = CMD_WATER_SPEED;  n_data = LEN_SHORT - 1;     end
                3: begin head = CMD_GROUND_SPEED; n_data = LEN_SHORT - 1;     end
                4: begin head = CMD_COURSE;       n_data = LEN_SHORT - 1;     end
                5: begin head = CMD_DEPTH;        n_data = LEN_DEPTH - 1;     end
                6: begin head = CMD_AUTOPILOT;    n_data = LEN_AUTOPILOT - 1; end
                default: begin head = CMD_ECHO;   n_data = LEN_SHORT - 1;     end
            endcase
            if (shape < 8)
                n_data = $urandom_range(0, n_data - 1);
            else if (shape < 16)
                n_data += $urandom_range(1, 14);
        end else begin
            head   = 8'($urandom);
            n_data = $urandom_range(0, 8);
        end
        for (int k = 0; k < n_data; k++) begin
            b = 8'($urandom);
            if (k == 0 && head == CMD_ECHO && $urandom_range(0, 3) != 0)
                b = 8'h00;
            body = {body, b};
        end
        queue_datagram(head, body);
    endtask

    // hold until every queued beat is in and every reading has come out
    task automatic wait_drained();
        while (beats_in != beats_queued || readings_due.size() != 0)
            @(negedge i_clk);
    endtask

    // sender: offers the next pending beat, holds it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !beat_taken) begin
            i_valid <= 1'b1;
        end else if (beats_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            i_valid      <= 1'b1;
            i_data_byte  <= beats_pending[0].data;
            i_is_command <= beats_pending[0].cmd;
            void'(beats_pending.pop_front());
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold_req && rx_hold_cnt < RX_HOLD_CYCLES) begin
            i_ready     <= 1'b0;
            rx_hold_cnt <= rx_hold_cnt + 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // monitor: predict on each input beat, check each output beat
    always @(posedge i_clk) begin
        beat_taken = i_rst_n && i_valid && o_ready;
        if (beat_taken) begin
            beats_in++;
            if (predict_reading(i_data_byte, i_is_command, next_reading))
                readings_due = {readings_due, next_reading};
        end
        if (i_rst_n && o_valid && i_ready) begin
            readings_out++;
            kind_seen[o_kind]++;
            if (readings_due.size() == 0) begin
                $error("unexpected reading: kind %0d value %0d course %0d",
                       o_kind, o_value, o_course);
                mismatches++;
            end else begin
                due_reading = readings_due.pop_front();
                if (o_kind !== due_reading.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", due_reading.kind, o_kind);
                    mismatches++;
                end
                if (o_value !== due_reading.value) begin
                    $error("value mismatch: expected %0d, actual %0d",
                           due_reading.value, o_value);
                    mismatches++;
                end
                if (o_course !== due_reading.course) begin
                    $error("course mismatch: expected %0d, actual %0d",
                           due_reading.course, o_course);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("tb_marine_bus_datagram_decoder failed");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        foreach (kind_seen[k])
            kind_seen[k] = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender light, receiver heavy idling
        tx_idle_pct = 36;
        rx_idle_pct = 75;
        // data before any command is dropped
        add_beat(8'h5A, 1'b0);
        // field extremes on wind angle and depth
        queue_datagram(CMD_WIND_ANGLE, '{8'hFF, 8'hFF, 8'hFF});
        queue_datagram(CMD_DEPTH, '{8'h00, 8'h00, 8'hFF, 8'hFF});
        // autopilot with both odd-heading bits and largest course
        queue_datagram(CMD_AUTOPILOT,
                       '{8'hF3, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        // echo with a non-zero second byte stays silent
        queue_datagram(CMD_ECHO, '{8'h01, 8'h00, 8'h55});
        // unknown type is counted but silent
        queue_datagram(8'h7F, '{8'h12, 8'h34});
        while (beats_queued < PHASE_BEATS)
            queue_random_datagram();
        wait_drained();

        // sender heavy, receiver light idling
        tx_idle_pct = 75;
        rx_idle_pct = 36;
        while (beats_queued < 2 * PHASE_BEATS)
            queue_random_datagram();
        wait_drained();

        // no idling, opened by a long receiver hold-off so the input backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        while (beats_queued < 3 * PHASE_BEATS)
            queue_random_datagram();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        foreach (kind_seen[k])
            if (kind_seen[k] != 0)
                kinds_hit++;
        $display("run covered %0d bus beats and %0d decoded readings over %0d of 8 kinds",
                 beats_in, readings_out, kinds_hit);
        $display("including short, long, saturated, unknown and silent-echo datagrams");
        if (mismatches == 0)
            $display("tb_marine_bus_datagram_decoder passed");
        else
            $display("tb_marine_bus_datagram_decoder failed");
        $finish;
    end

endmodule
